// ----- sv/sst_pkg.sv -----
package sst_pkg;

   localparam logic [1:0] FUNC_TEXT = 2'd0;
   localparam logic [1:0] FUNC_LED  = 2'd1;
   localparam logic [1:0] FUNC_SCAN = 2'd2;

   localparam logic CSR_SCAN_ENABLE = 1'b0;
   localparam logic CSR_MIRROR      = 1'b1;

   localparam logic [7:0] NUL_CODE = 8'h00;
   localparam logic [7:0] DOT_CODE = 8'h2E;
   localparam logic [7:0] DP_BIT   = 8'h80;
   localparam logic [7:0] BLANK    = 8'h00;

   typedef struct packed {
      logic       valid;
      logic [7:0] code;
      logic       last;
   } text_cmd_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] data;
   } rd_rsp_type;

   function automatic logic [7:0] glyph(input logic [7:0] code);
      logic [7:0] seg;
      seg = BLANK;
      case (code)
         8'h20: seg = 8'h00;
         8'h2A: seg = 8'h63;
         8'h2D: seg = 8'h40;
         8'h2E: seg = 8'h80;
         8'h3D: seg = 8'h48;
         8'h5B: seg = 8'h39;
         8'h5D: seg = 8'h0F;
         8'h5F: seg = 8'h08;
         8'h30: seg = 8'h3F;
         8'h31: seg = 8'h06;
         8'h32: seg = 8'h5B;
         8'h33: seg = 8'h4F;
         8'h34: seg = 8'h66;
         8'h35: seg = 8'h6D;
         8'h36: seg = 8'h7D;
         8'h37: seg = 8'h07;
         8'h38: seg = 8'h7F;
         8'h39: seg = 8'h6F;
         8'h41: seg = 8'h77;
         8'h43: seg = 8'h39;
         8'h45: seg = 8'h79;
         8'h46: seg = 8'h71;
         8'h48: seg = 8'h76;
         8'h49: seg = 8'h30;
         8'h4A: seg = 8'h1E;
         8'h4C: seg = 8'h38;
         8'h4E: seg = 8'h37;
         8'h50: seg = 8'h73;
         8'h53: seg = 8'h6D;
         8'h55: seg = 8'h3E;
         8'h62: seg = 8'h7C;
         8'h63: seg = 8'h58;
         8'h64: seg = 8'h5E;
         8'h6E: seg = 8'h54;
         8'h6F: seg = 8'h5C;
         8'h71: seg = 8'h67;
         8'h72: seg = 8'h50;
         8'h74: seg = 8'h78;
         8'h75: seg = 8'h1C;
         8'h79: seg = 8'h6E;
         default: seg = BLANK;
      endcase
      return seg;
   endfunction

endpackage

// ----- sv/seven_segment_text_scan_top.sv -----
// seven-segment display scanner with a streaming text front end
// req channel: one word per cycle while req_ready is high; req_func selects
// text character, led slot write or scan tick. text words build a string in a
// spare bank of the digit ram; the word marked last_char swaps banks, so all
// text digits change at once and digits past the string read blank
// rsp channel: one word per enabled scan tick, carrying the slot's segment
// byte and the physical digit to enable; other words give nothing
// path: a scan tick is registered in the read stage (ram read and slot fields)
// at the edge that accepts it, then moves into the output register. throughput
// is one word per cycle on both sides while rsp_ready is high, set by the
// single-port read of the digit ram
// when rsp_ready is low the output register holds and the read stage fills;
// req_ready drops only when both are full
// csr port: index 0 scan enable, index 1 mirror text digits; write only
// while idle
// reset: all slots blank, scan at slot 0, scanning disabled, no clearing pass
module seven_segment_text_scan_top #(
   parameter int TEXT_DIGITS  = 4,
   parameter int SLOT_COUNT   = 5,
   parameter int BUFFER_CHARS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   input  logic [7:0] req_led_bits,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_segments,
   output logic [2:0] rsp_digit_select,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic       csr_wdata
);

   localparam int PW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [PW-1:0] LAST_SLOT  = PW'(SLOT_COUNT - 1);
   localparam bit            LED_SHARED = (SLOT_COUNT <= TEXT_DIGITS);

   logic          enable_ff, enable_in;
   logic          mirror_ff, mirror_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    led_ff, led_in;
   logic          led_ovr_ff, led_ovr_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_use_led_ff, s1_use_led_in;
   logic [7:0]    s1_led_ff, s1_led_in;
   logic [2:0]    s1_phys_ff, s1_phys_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_seg_ff, rsp_seg_in;
   logic [2:0]    rsp_dig_ff, rsp_dig_in;

   logic                  accept;
   logic                  scan_go;
   logic                  advance;
   logic [4:0]            phys;
   sst_pkg::text_cmd_type cmd;
   sst_pkg::rd_rsp_type   rd_rsp;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign scan_go   = accept && (req_func == sst_pkg::FUNC_SCAN) && enable_ff;

   assign cmd.valid = accept && (req_func == sst_pkg::FUNC_TEXT);
   assign cmd.code  = req_char_code;
   assign cmd.last  = req_last_char;

   sst_text_store #(
      .TEXT_DIGITS  (TEXT_DIGITS),
      .BUFFER_CHARS (BUFFER_CHARS),
      .POS_W        (PW)
   ) u_text (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .rd_en  (scan_go),
      .rd_pos (pos_ff),
      .rd_rsp (rd_rsp)
   );

   always_comb begin
      enable_in = enable_ff;
      mirror_in = mirror_ff;
      if (csr_write) begin
         case (csr_index)
            sst_pkg::CSR_SCAN_ENABLE: enable_in = csr_wdata;
            sst_pkg::CSR_MIRROR:      mirror_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      led_in     = led_ff;
      led_ovr_in = led_ovr_ff;
      if (accept && req_func == sst_pkg::FUNC_LED) begin
         led_in     = req_led_bits;
         led_ovr_in = 1'b1;
      end
      if (cmd.valid && cmd.last) begin
         led_ovr_in = 1'b0;
      end
   end

   always_comb begin
      if (mirror_ff && pos_ff < TEXT_DIGITS) begin
         phys = 5'(TEXT_DIGITS - 1) - 5'(pos_ff);
      end else begin
         phys = 5'(pos_ff);
      end
   end

   always_comb begin
      pos_in        = pos_ff;
      s1_valid_in   = s1_valid_ff && !advance;
      s1_use_led_in = s1_use_led_ff;
      s1_led_in     = s1_led_ff;
      s1_phys_in    = s1_phys_ff;
      if (scan_go) begin
         pos_in        = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;
         s1_valid_in   = 1'b1;
         s1_use_led_in = (pos_ff == LAST_SLOT) && (!LED_SHARED || led_ovr_ff);
         s1_led_in     = led_ff;
         s1_phys_in    = phys[2:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_dig_in   = rsp_dig_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_use_led_ff) begin
            rsp_seg_in = s1_led_ff;
         end else begin
            rsp_seg_in = rd_rsp.hit ? rd_rsp.data : sst_pkg::BLANK;
         end
         rsp_dig_in = s1_phys_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         mirror_ff    <= 1'b0;
         pos_ff       <= '0;
         led_ff       <= '0;
         led_ovr_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         mirror_ff    <= mirror_in;
         pos_ff       <= pos_in;
         led_ff       <= led_in;
         led_ovr_ff   <= led_ovr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_use_led_ff <= s1_use_led_in;
      s1_led_ff     <= s1_led_in;
      s1_phys_ff    <= s1_phys_in;
      rsp_seg_ff    <= rsp_seg_in;
      rsp_dig_ff    <= rsp_dig_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_segments     = rsp_seg_ff;
   assign rsp_digit_select = rsp_dig_ff;

endmodule

// ----- sv/sst_text_store.sv -----
module sst_text_store #(
   parameter int TEXT_DIGITS  = 4,
   parameter int BUFFER_CHARS = 16,
   parameter int POS_W        = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sst_pkg::text_cmd_type cmd,
   input  logic                  rd_en,
   input  logic [POS_W-1:0]      rd_pos,
   output sst_pkg::rd_rsp_type   rd_rsp
);

   localparam int DW    = (TEXT_DIGITS > 1) ? $clog2(TEXT_DIGITS) : 1;
   localparam int NW    = $clog2(TEXT_DIGITS + 1);
   localparam int CW    = $clog2(BUFFER_CHARS);
   localparam int DEPTH = 2 ** (DW + 1);
   localparam logic [CW-1:0] MAX_CHARS = CW'(BUFFER_CHARS - 1);
   localparam logic [NW-1:0] FULL      = NW'(TEXT_DIGITS);

   // two banks: one shown, one being assembled
   logic [7:0]    mem [DEPTH];

   logic          bank_ff, bank_in;
   logic [NW-1:0] shown_ff, shown_in;
   logic [NW-1:0] next_ff, next_in;
   logic          prev_valid_ff, prev_valid_in;
   logic [DW-1:0] prev_idx_ff, prev_idx_in;
   logic [7:0]    prev_byte_ff, prev_byte_in;
   logic [CW-1:0] count_ff, count_in;
   logic          stopped_ff, stopped_in;
   logic          rd_hit_ff;
   logic [7:0]    rd_data_ff;

   logic          wr_en;
   logic [DW-1:0] wr_idx;
   logic [7:0]    wr_data;
   logic          stop;

   always_comb begin
      bank_in       = bank_ff;
      shown_in      = shown_ff;
      next_in       = next_ff;
      prev_valid_in = prev_valid_ff;
      prev_idx_in   = prev_idx_ff;
      prev_byte_in  = prev_byte_ff;
      count_in      = count_ff;
      stopped_in    = stopped_ff;
      wr_en         = 1'b0;
      wr_idx        = DW'(next_ff);
      wr_data       = sst_pkg::glyph(cmd.code);
      stop = (cmd.code == sst_pkg::NUL_CODE) || (count_ff >= MAX_CHARS) || (next_ff >= FULL);
      if (cmd.valid && !stopped_ff) begin
         if (stop) begin
            stopped_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
            wr_en    = 1'b1;
            if (cmd.code == sst_pkg::DOT_CODE && prev_valid_ff) begin
               wr_idx       = prev_idx_ff;
               wr_data      = prev_byte_ff | sst_pkg::DP_BIT;
               prev_byte_in = prev_byte_ff | sst_pkg::DP_BIT;
            end else begin
               prev_idx_in   = DW'(next_ff);
               prev_valid_in = 1'b1;
               prev_byte_in  = wr_data;
               next_in       = next_ff + 1'b1;
            end
         end
      end
      if (cmd.valid && cmd.last) begin
         shown_in      = next_in;
         bank_in       = ~bank_ff;
         next_in       = '0;
         prev_valid_in = 1'b0;
         prev_idx_in   = '0;
         count_in      = '0;
         stopped_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff       <= 1'b0;
         shown_ff      <= '0;
         next_ff       <= '0;
         prev_valid_ff <= 1'b0;
         prev_idx_ff   <= '0;
         count_ff      <= '0;
         stopped_ff    <= 1'b0;
         rd_hit_ff     <= 1'b0;
      end else begin
         bank_ff       <= bank_in;
         shown_ff      <= shown_in;
         next_ff       <= next_in;
         prev_valid_ff <= prev_valid_in;
         prev_idx_ff   <= prev_idx_in;
         count_ff      <= count_in;
         stopped_ff    <= stopped_in;
         if (rd_en) begin
            rd_hit_ff <= (rd_pos < TEXT_DIGITS) && (rd_pos < shown_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      prev_byte_ff <= prev_byte_in;
      if (wr_en) begin
         mem[{~bank_ff, wr_idx}] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[{bank_ff, DW'(rd_pos)}];
      end
   end

   assign rd_rsp.hit  = rd_hit_ff;
   assign rd_rsp.data = rd_data_ff;

endmodule

// ----- sv/sst_checker.sv -----
module sst_checker #(
   parameter int SLOT_COUNT = 5
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_func,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_segments,
   input logic [2:0] rsp_digit_select,
   input logic       csr_write,
   input logic       csr_index,
   input logic       csr_wdata
);

   logic mirror_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_ff <= 1'b0;
      end else if (csr_write && csr_index == sst_pkg::CSR_MIRROR) begin
         mirror_ff <= csr_wdata;
      end
   end

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_segments)
         && $stable(rsp_digit_select))
      else $error("rsp word changed while stalled");

   // empty output means the input side is open
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // unmirrored digit select is the slot position
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !mirror_ff |-> rsp_digit_select < SLOT_COUNT)
      else $error("digit select beyond slot count");

   // a scan word needs an accepted scan tick before it
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(req_valid && req_ready && req_func == sst_pkg::FUNC_SCAN)
         && !(req_valid && req_ready && req_func == sst_pkg::FUNC_SCAN) |=> !rsp_valid)
      else $error("result without a scan tick");

endmodule

bind seven_segment_text_scan_top sst_checker #(.SLOT_COUNT(SLOT_COUNT)) u_sst_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_func         (req_func),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_segments     (rsp_segments),
   .rsp_digit_select (rsp_digit_select),
   .csr_write        (csr_write),
   .csr_index        (csr_index),
   .csr_wdata        (csr_wdata)
);

// ----- sim/seven_segment_text_scan_top_test.sv -----
`timescale 1ns / 1ps

module seven_segment_text_scan_top_test;

   localparam int TEXT_DIGITS       = 4;
   localparam int SLOT_COUNT        = 5;
   localparam int BUFFER_CHARS      = 16;
   localparam int PIPE_CYCLES       = 2;
   localparam int STUCK_LIMIT       = 2000;
   localparam int WORDS_PER_SEGMENT = 100;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] segments;
      logic [2:0] digit_select;
   } scan_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_func = sst_pkg::FUNC_TEXT;
   logic [7:0] req_char_code = 8'h00;
   logic       req_last_char = 1'b0;
   logic [7:0] req_led_bits = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_segments;
   logic [2:0] rsp_digit_select;
   logic       csr_write = 1'b0;
   logic       csr_index = sst_pkg::CSR_SCAN_ENABLE;
   logic       csr_wdata = 1'b0;

   // display state as the block should hold it
   logic [7:0]  shown_slot [SLOT_COUNT];
   logic [7:0]  text_buf [TEXT_DIGITS];
   int unsigned fill_digit;
   int unsigned prev_digit;
   int unsigned taken_chars;
   int unsigned scan_slot;
   bit          have_prev;
   bit          text_closed;
   bit          scan_on;
   bit          mirror_on;

   scan_word_type expected_scan_q [$];
   scan_word_type checked_word;
   string         glyph_chars = "0123456789ACEFHIJLNPSUbcdnoqrty -*=[]_.";

   int fail_count    = 0;
   int words_sent    = 0;
   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   int rsp_hold      = 0;
   int stuck_cycles  = 0;

   seven_segment_text_scan_top #(
      .TEXT_DIGITS  (TEXT_DIGITS),
      .SLOT_COUNT   (SLOT_COUNT),
      .BUFFER_CHARS (BUFFER_CHARS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_char_code    (req_char_code),
      .req_last_char    (req_last_char),
      .req_led_bits     (req_led_bits),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_segments     (rsp_segments),
      .rsp_digit_select (rsp_digit_select),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] segment_pattern(input logic [7:0] code);
      case (code)
         " ": return 8'h00;
         "*": return 8'h63;
         "-": return 8'h40;
         ".": return 8'h80;
         "=": return 8'h48;
         "[": return 8'h39;
         "]": return 8'h0F;
         "_": return 8'h08;
         "0": return 8'h3F;
         "1": return 8'h06;
         "2": return 8'h5B;
         "3": return 8'h4F;
         "4": return 8'h66;
         "5": return 8'h6D;
         "6": return 8'h7D;
         "7": return 8'h07;
         "8": return 8'h7F;
         "9": return 8'h6F;
         "A": return 8'h77;
         "C": return 8'h39;
         "E": return 8'h79;
         "F": return 8'h71;
         "H": return 8'h76;
         "I": return 8'h30;
         "J": return 8'h1E;
         "L": return 8'h38;
         "N": return 8'h37;
         "P": return 8'h73;
         "S": return 8'h6D;
         "U": return 8'h3E;
         "b": return 8'h7C;
         "c": return 8'h58;
         "d": return 8'h5E;
         "n": return 8'h54;
         "o": return 8'h5C;
         "q": return 8'h67;
         "r": return 8'h50;
         "t": return 8'h78;
         "u": return 8'h1C;
         "y": return 8'h6E;
         default: return sst_pkg::BLANK;
      endcase
   endfunction

   function automatic void clear_text();
      foreach (text_buf[i]) text_buf[i] = sst_pkg::BLANK;
      fill_digit  = 0;
      prev_digit  = 0;
      taken_chars = 0;
      have_prev   = 1'b0;
      text_closed = 1'b0;
   endfunction

   function automatic void reset_display_model();
      foreach (shown_slot[i]) shown_slot[i] = sst_pkg::BLANK;
      clear_text();
      scan_slot = 0;
      scan_on   = 1'b0;
      mirror_on = 1'b0;
   endfunction

   function automatic void take_text_char(input logic [7:0] code);
      if (text_closed) return;
      if (code == sst_pkg::NUL_CODE || taken_chars >= BUFFER_CHARS - 1
          || fill_digit >= TEXT_DIGITS) begin
         text_closed = 1'b1;
         return;
      end
      taken_chars++;
      // a point joins the previous digit when there is one
      if (code == sst_pkg::DOT_CODE && have_prev && prev_digit < TEXT_DIGITS) begin
         text_buf[prev_digit] = text_buf[prev_digit] | sst_pkg::DP_BIT;
         return;
      end
      text_buf[fill_digit] = segment_pattern(code);
      prev_digit = fill_digit;
      have_prev  = 1'b1;
      fill_digit++;
   endfunction

   function automatic void predict_word(input logic [1:0] func, input logic [7:0] code,
                                        input logic last, input logic [7:0] leds);
      scan_word_type shown;
      case (func)
         sst_pkg::FUNC_TEXT: begin
            take_text_char(code);
            if (last) begin
               for (int i = 0; i < TEXT_DIGITS && i < SLOT_COUNT; i++)
                  shown_slot[i] = (i < fill_digit) ? text_buf[i] : sst_pkg::BLANK;
               clear_text();
            end
         end
         sst_pkg::FUNC_LED: shown_slot[SLOT_COUNT - 1] = leds;
         sst_pkg::FUNC_SCAN: begin
            if (scan_on) begin
               shown.segments     = shown_slot[scan_slot];
               shown.digit_select = (mirror_on && scan_slot < TEXT_DIGITS) ?
                                    3'(TEXT_DIGITS - 1 - scan_slot) : 3'(scan_slot);
               expected_scan_q.push_back(shown);
               scan_slot = (scan_slot + 1 >= SLOT_COUNT) ? 0 : scan_slot + 1;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [7:0] pick_text_char();
      int r;
      r = $urandom_range(99);
      if (r < 30) return sst_pkg::DOT_CODE;
      if (r < 40) return 8'($urandom_range(1, 255));
      if (r < 44) return sst_pkg::NUL_CODE;
      return glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
   endfunction

   task automatic send_word(input logic [1:0] func, input logic [7:0] code,
                            input logic last, input logic [7:0] leds);
      @(negedge clock);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_char_code <= code;
      req_last_char <= last;
      req_led_bits  <= leds;
      do @(posedge clock); while (!req_ready);
      predict_word(func, code, last, leds);
      words_sent++;
   endtask

   task automatic send_text(input logic [7:0] code, input logic last);
      send_word(sst_pkg::FUNC_TEXT, code, last, 8'($urandom));
   endtask

   task automatic send_scan();
      send_word(sst_pkg::FUNC_SCAN, 8'($urandom), 1'($urandom), 8'($urandom));
   endtask

   task automatic scan_round();
      repeat (SLOT_COUNT) send_scan();
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_scan_q.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES + 2) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (index == sst_pkg::CSR_SCAN_ENABLE) scan_on = value;
      else mirror_on = value;
   endtask

   task automatic send_random_burst();
      int pick;
      int len;
      pick = $urandom_range(99);
      if (pick < 60) begin
         len = $urandom_range(1, 6);
         for (int i = 1; i <= len; i++) begin
            send_text(pick_text_char(), i == len);
            if ($urandom_range(99) < 20) send_scan();
         end
      end else if (pick < 70) begin
         // string left open, carried into the next one
         repeat ($urandom_range(1, 3)) send_text(pick_text_char(), 1'b0);
      end else if (pick < 78) begin
         // run of points up to and past the character limit
         send_text(glyph_chars[$urandom_range(0, glyph_chars.len() - 2)], 1'b0);
         repeat ($urandom_range(13, 16)) send_text(sst_pkg::DOT_CODE, 1'b0);
         send_text(pick_text_char(), 1'b1);
      end else if (pick < 85) begin
         send_word(sst_pkg::FUNC_LED, 8'($urandom), 1'($urandom), 8'($urandom));
      end else begin
         send_word(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 8'($urandom));
      end
      repeat ($urandom_range(0, 5)) send_scan();
   endtask

   task automatic test_reset_state();
      send_word(sst_pkg::FUNC_SCAN, 8'h00, 1'b0, 8'h00);
      send_word(FUNC_UNUSED, 8'hFF, 1'b1, 8'hFF);
      wait_quiet();
      write_csr(sst_pkg::CSR_SCAN_ENABLE, 1'b1);
      write_csr(sst_pkg::CSR_MIRROR, 1'b0);
      send_scan();
   endtask

   task automatic test_text_strings();
      // leading point takes its own digit, then a point joins the A
      send_text(sst_pkg::DOT_CODE, 1'b0);
      send_text("A", 1'b0);
      send_text(sst_pkg::DOT_CODE, 1'b0);
      send_text(8'hFF, 1'b1);
      send_word(sst_pkg::FUNC_LED, 8'h00, 1'b0, 8'hFF);
      // unknown glyphs blank, fifth character finds the digits full
      send_text("1", 1'b0);
      send_text("2", 1'b0);
      send_text("Z", 1'b0);
      send_text(8'h80, 1'b0);
      send_text("5", 1'b1);
      scan_round();
      wait_quiet();
      write_csr(sst_pkg::CSR_MIRROR, 1'b1);
      scan_round();
      send_text(sst_pkg::NUL_CODE, 1'b1);
      send_word(sst_pkg::FUNC_LED, 8'h00, 1'b0, 8'h00);
   endtask

   task automatic test_random_traffic();
      int gap_pct [4]   = '{0, 46, 0, 17};
      int stall_pct [4] = '{0, 0, 46, 17};
      int seg_index;
      int seg_end;
      seg_index = 0;
      for (int p = 0; p < 4; p++) begin
         for (int s = 0; s < 3; s++) begin
            wait_quiet();
            write_csr(sst_pkg::CSR_SCAN_ENABLE, seg_index % 3 != 2);
            write_csr(sst_pkg::CSR_MIRROR, 1'(seg_index % 2));
            send_gap_pct  = gap_pct[p];
            rsp_stall_pct = stall_pct[p];
            seg_end = words_sent + WORDS_PER_SEGMENT;
            while (words_sent < seg_end) send_random_burst();
            seg_index++;
         end
      end
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      wait_quiet();
      write_csr(sst_pkg::CSR_SCAN_ENABLE, 1'b1);
      write_csr(sst_pkg::CSR_MIRROR, 1'b0);
      rsp_hold = 300;
      repeat (40) send_scan();
      wait_quiet();
      send_text("8", 1'b0);
      send_text(sst_pkg::DOT_CODE, 1'b1);
      repeat (2 * SLOT_COUNT) send_scan();
   endtask

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_scan_q.size() == 0) begin
            $error("rsp word with nothing expected: segments %0h digit_select %0d",
                   rsp_segments, rsp_digit_select);
            fail_count++;
         end else begin
            checked_word = expected_scan_q.pop_front();
            if (rsp_segments !== checked_word.segments) begin
               $error("segments expected %0h actual %0h", checked_word.segments, rsp_segments);
               fail_count++;
            end
            if (rsp_digit_select !== checked_word.digit_select) begin
               $error("digit_select expected %0d actual %0d",
                      checked_word.digit_select, rsp_digit_select);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles = 0;
      end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stuck_cycles++;
      end
   end

   initial begin
      reset_display_model();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_text_strings();
      test_random_traffic();
      test_backpressure();
      wait_quiet();
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- seven_segment_text_scan_top.f -----
sv/sst_pkg.sv
sv/sst_text_store.sv
sv/seven_segment_text_scan_top.sv
sv/sst_checker.sv
sim/seven_segment_text_scan_top_test.sv
